// ===== rtl/orq_pkg.sv =====
// ----------------------------------------------------------------------------
// orq_pkg
// shared types and fixed field widths of the overwriting ring queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package orq_pkg;

	// operation codes carried in the func field
	typedef enum logic [1:0] {
		FUNC_PUSH      = 2'd0,
		FUNC_POP       = 2'd1,
		FUNC_PEEK_OLD  = 2'd2,
		FUNC_PEEK_BACK = 2'd3
	} func_t;

	localparam int MSG_PORT_W = 64;
	localparam int BACK_W     = 4;
	localparam int DROP_W     = 32;

endpackage

// ===== rtl/orq_req_if.sv =====
// ----------------------------------------------------------------------------
// orq_req_if
// request channel: operation word with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface orq_req_if;

	logic                                valid;
	logic                                ready;
	orq_pkg::func_t                      func;
	logic [orq_pkg::MSG_PORT_W-1:0]      msg_data;
	logic [orq_pkg::BACK_W-1:0]          back;

	modport source (output valid, output func, output msg_data, output back, input ready);
	modport sink   (input valid, input func, input msg_data, input back, output ready);

endinterface

// ===== rtl/orq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// orq_rsp_if
// response channel: result word with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface orq_rsp_if #(
	parameter int DEPTH_W = 5
);

	logic                                valid;
	logic                                ready;
	logic                                found;
	logic [orq_pkg::MSG_PORT_W-1:0]      msg_out;
	logic [DEPTH_W-1:0]                  depth_now;
	logic [orq_pkg::DROP_W-1:0]          drop_total;

	modport source (
		output valid, output found, output msg_out, output depth_now, output drop_total,
		input ready
	);
	modport sink (
		input valid, input found, input msg_out, input depth_now, input drop_total,
		output ready
	);

endinterface

// ===== rtl/orq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// orq_slot_ram
// slot storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orq_slot_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/orq_ring_ctrl.sv =====
// ----------------------------------------------------------------------------
// orq_ring_ctrl
// head, count and drop counter; slot addressing for each operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orq_ring_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW         = $clog2(QUEUE_DEPTH),
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  orq_pkg::func_t                func,
	input  logic [orq_pkg::BACK_W-1:0]    back,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	output logic                          hit,
	output logic [CW-1:0]                 count_cur,
	output logic [CW-1:0]                 count_next,
	output logic [orq_pkg::DROP_W-1:0]    drops_next
);

	localparam int SW = ((CW > orq_pkg::BACK_W) ? CW : orq_pkg::BACK_W) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [orq_pkg::DROP_W-1:0]   drops_q;

	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_next;
	logic          full;
	logic          empty;
	logic [SW-1:0] tail_sum;
	logic [AW-1:0] tail_addr;
	logic [SW-1:0] back_s;
	logic [SW-1:0] count_s;
	logic          back_hit;
	logic [SW-1:0] back_sum;
	logic [AW-1:0] back_addr;

	always_comb begin
		head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		full     = (count_q == DEPTH_C);
		empty    = (count_q == '0);

		// tail slot; when full the new word lands on the evicted oldest slot
		tail_sum  = SW'(head_q) + SW'(count_q);
		tail_addr = full ? head_q :
			((tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum));

		// look-back slot: head + count - 1 - back, below twice the depth
		back_s    = SW'(back);
		count_s   = SW'(count_q);
		back_hit  = (back_s < count_s);
		back_sum  = SW'(head_q) + count_s - SW'(1) - back_s;
		back_addr = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = tail_addr;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		hit        = 1'b0;
		head_next  = head_q;
		count_next = count_q;
		drops_next = drops_q;
		case (func)
			orq_pkg::FUNC_PUSH: begin
				wr_en = 1'b1;
				hit   = 1'b1;
				if (full) begin
					head_next  = head_inc;
					drops_next = drops_q + 1'b1;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			orq_pkg::FUNC_POP: begin
				if (!empty) begin
					rd_en      = 1'b1;
					hit        = 1'b1;
					head_next  = head_inc;
					count_next = count_q - 1'b1;
				end
			end
			orq_pkg::FUNC_PEEK_OLD: begin
				if (!empty) begin
					rd_en = 1'b1;
					hit   = 1'b1;
				end
			end
			orq_pkg::FUNC_PEEK_BACK: begin
				if (back_hit) begin
					rd_en   = 1'b1;
					rd_addr = back_addr;
					hit     = 1'b1;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			drops_q <= '0;
		end else if (accept) begin
			head_q  <= head_next;
			count_q <= count_next;
			drops_q <= drops_next;
		end
	end

	assign count_cur = count_q;

endmodule

// ===== rtl/overwriting_ring_queue_core.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_queue_core
// ring queue of message words; push into a full queue evicts the oldest word
// result: valid in the cycle after the request word is accepted
// throughput: one word per cycle while the response side keeps ready high
// set by the single registered pass through control and slot ram read port
// reset: head, count, drop counter and result valid clear; slot ram is not
// cleared since a slot is read only after it was written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module overwriting_ring_queue_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MSG_WIDTH   = 64,
	localparam int AW         = $clog2(QUEUE_DEPTH),
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	orq_req_if.sink    req,
	orq_rsp_if.source  rsp
);

	// handshake on the request side
	logic accept;

	// control to slot ram
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic [MSG_WIDTH-1:0]          rd_data;

	// per-word results from control
	logic                          hit;
	logic [CW-1:0]                 count_cur;
	logic [CW-1:0]                 count_next;
	logic [orq_pkg::DROP_W-1:0]    drops_next;

	// result register stage
	logic                          valid_s1;
	logic                          found_s1;
	logic                          rd_hit_s1;
	logic [CW-1:0]                 depth_s1;
	logic [orq_pkg::DROP_W-1:0]    drop_s1;

	// the result register only advances when it is empty or being drained,
	// which also keeps the ram read data stable during a stall
	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;

	orq_ring_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (req.func),
		.back       (req.back),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.hit        (hit),
		.count_cur  (count_cur),
		.count_next (count_next),
		.drops_next (drops_next)
	);

	// only the low MSG_WIDTH bits of a pushed word are kept
	orq_slot_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (MSG_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en && accept),
		.wr_addr (wr_addr),
		.wr_data (req.msg_data[MSG_WIDTH-1:0]),
		.rd_en   (rd_en && accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			found_s1  <= 1'b0;
			rd_hit_s1 <= 1'b0;
			depth_s1  <= '0;
			drop_s1   <= '0;
		end else if (accept) begin
			valid_s1  <= 1'b1;
			found_s1  <= hit;
			rd_hit_s1 <= rd_en;
			depth_s1  <= count_next;
			drop_s1   <= drops_next;
		end else if (rsp.ready) begin
			valid_s1  <= 1'b0;
		end
	end

	// push and misses report a zero word
	assign rsp.valid      = valid_s1;
	assign rsp.found      = found_s1;
	assign rsp.msg_out    = rd_hit_s1 ? orq_pkg::MSG_PORT_W'(rd_data) : '0;
	assign rsp.depth_now  = depth_s1;
	assign rsp.drop_total = drop_s1;

	// a push always reports found on the next result
	a_push_found: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.func == orq_pkg::FUNC_PUSH) |=> valid_s1 && found_s1 && !rd_hit_s1)
		else $error("push did not report found");

	// reported count never exceeds the queue depth
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (depth_s1 <= CW'(QUEUE_DEPTH)))
		else $error("depth_now beyond queue depth");

	// a successful pop shrinks the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.func == orq_pkg::FUNC_POP) && (count_cur != '0)
		|=> depth_s1 == CW'($past(count_cur) - 1'b1))
		else $error("pop count mismatch");

	// the drop counter moves only on a push
	a_drop_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.func != orq_pkg::FUNC_PUSH) |-> drops_next == drop_s1 || !valid_s1)
		else $error("drop counter moved without a push");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for overwriting_ring_queue_core: a queue of request
// words feeds a clocked driver, a clocked monitor runs a ring queue model
// on every accepted request and compares each response word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int QDEPTH       = 16;  // model index math wraps on 4 bits
	localparam int MSG_W        = 64;
	localparam int RANDOM_WORDS = 2000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [orq_pkg::MSG_PORT_W-1:0] WORD_MASK =
		{orq_pkg::MSG_PORT_W{1'b1}} >> (orq_pkg::MSG_PORT_W - MSG_W);

	// one request word waiting to be driven
	typedef struct {
		orq_pkg::func_t                 op;
		logic [orq_pkg::MSG_PORT_W-1:0] data;
		logic [orq_pkg::BACK_W-1:0]     back_n;
		bit                             drain_first;  // hold off until all responses are in
	} ring_cmd_t;

	// one response word as the model predicts it
	typedef struct {
		logic                           found;
		logic [orq_pkg::MSG_PORT_W-1:0] msg;
		logic [4:0]                     depth;
		logic [orq_pkg::DROP_W-1:0]     drops;
	} ring_result_t;

	logic clk;
	logic arst_n;

	orq_req_if              req_ch ();
	orq_rsp_if #(.DEPTH_W(5)) rsp_ch ();

	overwriting_ring_queue_core #(
		.QUEUE_DEPTH(QDEPTH),
		.MSG_WIDTH  (MSG_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// stimulus and scoreboard storage
	ring_cmd_t    pending_q[$];
	ring_result_t expected_q[$];

	// model state: ring of words, oldest slot, live count, evictions
	logic [orq_pkg::MSG_PORT_W-1:0] ring_word [QDEPTH];
	logic [3:0]                     oldest_ptr;
	logic [4:0]                     live_cnt;
	logic [orq_pkg::DROP_W-1:0]     drop_cnt;

	int  total_cmds;
	int  words_issued;
	int  mismatch_cnt;
	int  cycle_cnt;
	bit  word_taken;

	always #5 clk = ~clk;

	// apply one request to the model and queue the response it must produce
	task automatic ring_apply(input orq_pkg::func_t op,
			input logic [orq_pkg::MSG_PORT_W-1:0] data,
			input logic [orq_pkg::BACK_W-1:0] back_n);
		ring_result_t r;
		logic [3:0]   slot;
		r.found = 1'b0;
		r.msg   = '0;
		case (op)
			orq_pkg::FUNC_PUSH: begin
				// full queue: the oldest word is evicted before the store
				if (live_cnt == 5'(QDEPTH)) begin
					oldest_ptr = oldest_ptr + 4'd1;
					live_cnt   = 5'(QDEPTH - 1);
					drop_cnt   = drop_cnt + 1'b1;
				end
				slot            = 4'(5'(oldest_ptr) + live_cnt);
				ring_word[slot] = data & WORD_MASK;
				live_cnt        = live_cnt + 5'd1;
				r.found         = 1'b1;
			end
			orq_pkg::FUNC_POP, orq_pkg::FUNC_PEEK_OLD: begin
				if (live_cnt != 5'd0) begin
					r.found = 1'b1;
					r.msg   = ring_word[oldest_ptr];
					if (op == orq_pkg::FUNC_POP) begin
						oldest_ptr = oldest_ptr + 4'd1;
						live_cnt   = live_cnt - 5'd1;
					end
				end
			end
			default: begin
				// look-back from the newest word, miss at or past the count
				if (5'(back_n) < live_cnt) begin
					slot    = 4'(5'(oldest_ptr) + live_cnt - 5'd1 - 5'(back_n));
					r.found = 1'b1;
					r.msg   = ring_word[slot];
				end
			end
		endcase
		r.msg   = r.msg & WORD_MASK;
		r.depth = live_cnt;
		r.drops = drop_cnt;
		expected_q.push_back(r);
	endtask

	task automatic queue_cmd(input orq_pkg::func_t op,
			input logic [orq_pkg::MSG_PORT_W-1:0] data,
			input logic [orq_pkg::BACK_W-1:0] back_n, input bit drain_first);
		ring_cmd_t c;
		c.op          = op;
		c.data        = data;
		c.back_n      = back_n;
		c.drain_first = drain_first;
		pending_q.push_back(c);
	endtask

	// idle percentages per phase: sender light / receiver heavy, swapped, none
	function automatic int tx_idle_pct();
		int ph;
		ph = (words_issued * 3) / (total_cmds == 0 ? 1 : total_cmds);
		case (ph)
			0:       return 22;
			1:       return 80;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct();
		int ph;
		ph = (words_issued * 3) / (total_cmds == 0 ? 1 : total_cmds);
		case (ph)
			0:       return 80;
			1:       return 22;
			default: return 0;
		endcase
	endfunction

	// driver: everything toward the block changes on the falling edge
	always @(negedge clk) begin
		ring_cmd_t nxt;
		bit        drain_hold;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			// a raised valid stays up with the same word until it is taken
			if (!req_ch.valid || word_taken) begin
				drain_hold = (pending_q.size() != 0) && pending_q[0].drain_first
					&& (expected_q.size() != 0);
				if (pending_q.size() != 0 && !drain_hold
						&& $urandom_range(99) >= tx_idle_pct()) begin
					nxt = pending_q.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.func     <= nxt.op;
					req_ch.msg_data <= nxt.data;
					req_ch.back     <= nxt.back_n;
					words_issued++;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
		end
	end

	// monitor: handshakes are sampled on the rising edge
	always @(posedge clk) begin
		ring_result_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if (arst_n) begin
			// accepted request word: run the model
			word_taken = req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				ring_apply(req_ch.func, req_ch.msg_data, req_ch.back);
			end
			// accepted response word: compare with the oldest prediction
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected response word found=%0b msg=%h depth=%0d drops=%0d",
						$time, rsp_ch.found, rsp_ch.msg_out, rsp_ch.depth_now,
						rsp_ch.drop_total);
					mismatch_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.found !== want.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, want.found, rsp_ch.found);
						mismatch_cnt++;
					end
					if (rsp_ch.msg_out !== want.msg) begin
						$display("%0t: msg_out expected %h actual %h",
							$time, want.msg, rsp_ch.msg_out);
						mismatch_cnt++;
					end
					if (rsp_ch.depth_now !== want.depth) begin
						$display("%0t: depth_now expected %0d actual %0d",
							$time, want.depth, rsp_ch.depth_now);
						mismatch_cnt++;
					end
					if (rsp_ch.drop_total !== want.drops) begin
						$display("%0t: drop_total expected %0d actual %0d",
							$time, want.drops, rsp_ch.drop_total);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	initial begin
		int             random_issued;
		int             burst_kind;
		int             burst_len;
		int             roll;
		orq_pkg::func_t op;
		bit             drain;

		// known levels on every input from time zero
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = orq_pkg::FUNC_PUSH;
		req_ch.msg_data = '0;
		req_ch.back     = '0;
		rsp_ch.ready    = 1'b0;
		oldest_ptr      = '0;
		live_cnt        = '0;
		drop_cnt        = '0;
		words_issued    = 0;
		mismatch_cnt    = 0;
		cycle_cnt       = 0;
		word_taken      = 1'b0;
		total_cmds      = 0;

		// directed: every operation against an empty queue
		queue_cmd(orq_pkg::FUNC_PEEK_OLD, '0, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_POP, '1, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd15, 1'b0);
		// extreme words, look-back hit and miss at the count
		queue_cmd(orq_pkg::FUNC_PUSH, '0, 4'd15, 1'b0);
		queue_cmd(orq_pkg::FUNC_PUSH, '1, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_OLD, '0, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd1, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd2, 1'b0);
		// fill to capacity with alternating patterns
		for (int k = 0; k < QDEPTH - 2; k++)
			queue_cmd(orq_pkg::FUNC_PUSH,
				(k % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555,
				4'(k), 1'b0);
		// push into a full queue evicts the oldest word
		queue_cmd(orq_pkg::FUNC_PUSH, 64'h8000_0000_0000_0001, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PUSH, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd15, 1'b0);
		queue_cmd(orq_pkg::FUNC_POP, '0, 4'd0, 1'b0);
		queue_cmd(orq_pkg::FUNC_PEEK_BACK, '0, 4'd15, 1'b0);

		// random: bursts that fill, drain, peek or mix, so the queue swings
		// between empty, full and overflowing
		random_issued = 0;
		while (random_issued < RANDOM_WORDS) begin
			burst_kind = $urandom_range(3);
			burst_len  = $urandom_range(40, 4);
			for (int k = 0; k < burst_len; k++) begin
				roll = $urandom_range(99);
				case (burst_kind)
					0:       op = (roll < 80) ? orq_pkg::FUNC_PUSH
						: orq_pkg::func_t'($urandom_range(3));
					1:       op = (roll < 70) ? orq_pkg::FUNC_POP
						: orq_pkg::func_t'($urandom_range(3));
					2:       op = (roll < 60) ? orq_pkg::FUNC_PEEK_BACK
						: ((roll < 80) ? orq_pkg::FUNC_PEEK_OLD : orq_pkg::FUNC_PUSH);
					default: op = orq_pkg::func_t'($urandom_range(3));
				endcase
				// occasionally let the pipe run dry before the next word
				drain = (random_issued % 500 == 250) || ($urandom_range(199) == 0);
				queue_cmd(op, {$urandom, $urandom}, 4'($urandom_range(15)), drain);
				random_issued++;
			end
		end
		total_cmds = pending_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all words sent, all responses in, then a wait for strays
		while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
